// ===== rtl/core/ctt_pkg.sv =====
// Shared types, codes and character helpers for the configuration text tokenizer.
package ctt_pkg;

    localparam int LINE_BITS = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    // Scanner modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_QUOTED  = 4'd2;
    localparam logic [3:0] M_IDENT   = 4'd3;
    localparam logic [3:0] M_NUMBER  = 4'd4;
    localparam logic [3:0] M_MINUS   = 4'd5;
    localparam logic [3:0] M_ERROR   = 4'd6;

    // Token kinds
    localparam logic [3:0] K_EOF       = 4'd0;
    localparam logic [3:0] K_COLON     = 4'd1;
    localparam logic [3:0] K_COMMA     = 4'd2;
    localparam logic [3:0] K_EQUALS    = 4'd3;
    localparam logic [3:0] K_SEMICOLON = 4'd4;
    localparam logic [3:0] K_OPEN      = 4'd5;
    localparam logic [3:0] K_CLOSE     = 4'd6;
    localparam logic [3:0] K_STRING    = 4'd7;
    localparam logic [3:0] K_IDENT     = 4'd8;
    localparam logic [3:0] K_NUMBER    = 4'd9;
    localparam logic [3:0] K_BAD       = 4'd10;
    localparam logic [3:0] K_OPENSTR   = 4'd11;

    // Characters
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_EQUALS = 8'h3D;
    localparam logic [7:0] C_SEMI   = 8'h3B;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_UNDER  = 8'h5F;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_NUL    = 8'h00;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [7:0]  token_char;
        logic        char_valid;
        logic        first_of_token;
        logic        last_of_token;
        logic [15:0] line_number;
    } t_tok;

    function automatic t_tok mk_tok(logic [3:0] kind, logic [7:0] ch, logic valid,
                                    logic first, logic last, logic [15:0] line);
        t_tok t;
        t.token_kind     = kind;
        t.token_char     = valid ? ch : 8'd0;
        t.char_valid     = valid;
        t.first_of_token = first;
        t.last_of_token  = last;
        t.line_number    = line;
        return t;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_numch(logic [7:0] c);
        return is_digit(c) || (c == C_DOT);
    endfunction

    function automatic logic is_identch(logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == C_UNDER);
    endfunction

endpackage

// ===== rtl/core/ctt_if.sv =====
// Valid/ready channel interfaces for the tokenizer input bytes and token results.
interface ctt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_end;

    modport source (output valid, output data_byte, output is_end, input ready);
    modport sink   (input valid, input data_byte, input is_end, output ready);
endinterface

interface ctt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  token_char;
    logic        char_valid;
    logic        first_of_token;
    logic        last_of_token;
    logic [15:0] line_number;

    modport source (output valid, output token_kind, output token_char, output char_valid,
                    output first_of_token, output last_of_token, output line_number,
                    input ready);
    modport sink   (input valid, input token_kind, input token_char, input char_valid,
                    input first_of_token, input last_of_token, input line_number,
                    output ready);
endinterface

// ===== rtl/core/config_text_tokenizer.sv =====
// Top level of the streaming configuration text tokenizer.
//
// Input channel i_in carries one text byte per transfer (data_byte, is_end).
// Blanks and # comments are skipped, lines are counted, and each token is
// reported on o_out as a run of results, one content byte per result, with
// kind, line number and first/last marks. An end item (is_end or a zero byte)
// flushes any pending token or error, reports EOF and restarts at line 1.
//
// Each accepted byte is decoded in the cycle of its transfer against the
// scanner state and yields zero, one or two results, which are written into a
// four-entry result queue; the head of the queue drives o_out directly, so with
// the queue empty the first result of a byte is visible in the cycle after its transfer.
// A byte is taken whenever the queue has room for two results, so one byte per
// cycle is sustained while the receiver takes results as fast as they come;
// bytes that yield two results are limited by the one-result-per-cycle output.
// When the receiver stalls, the queue fills and i_in.ready drops until space
// frees up; nothing is lost or reordered.
// Reset (i_rst_n low, synchronous) empties the queue and returns the scanner
// to idle on line 1.
module config_text_tokenizer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ctt_in_if.sink          i_in,
    ctt_out_if.source       o_out
);

    logic [3:0]                    r_mode, n_mode;
    logic [7:0]                    r_held, n_held;
    logic                          r_hv, n_hv;
    logic                          r_hf, n_hf;
    logic [ctt_pkg::LINE_BITS-1:0] r_line, n_line;
    logic                          r_nl, n_nl;

    ctt_pkg::t_tok                 r_fifo [ctt_pkg::FIFO_DEPTH];
    logic [ctt_pkg::FIFO_AW-1:0]   r_wp, r_rp;
    logic [ctt_pkg::FIFO_AW:0]     r_cnt;

    ctt_pkg::t_tok                 res [2];
    logic [1:0]                    nres;
    logic                          in_xfer, out_xfer;
    logic [7:0]                    c;
    logic                          is_eoi;
    logic                          do_disp;
    logic [15:0]                   line16;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;
    assign c        = i_in.data_byte;
    assign is_eoi   = i_in.is_end || (c == ctt_pkg::C_NUL);
    assign line16   = 16'(r_line);

    // Room for two results keeps the queue from overflowing on any byte.
    assign i_in.ready = (r_cnt <= (ctt_pkg::FIFO_AW+1)'(ctt_pkg::FIFO_DEPTH - 2));

    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_hv    = r_hv;
        n_hf    = r_hf;
        n_line  = r_line;
        n_nl    = r_nl;
        nres    = 2'd0;
        do_disp = 1'b0;
        res[0]  = '0;
        res[1]  = '0;

        if (is_eoi) begin
            unique case (r_mode) inside
                ctt_pkg::M_IDENT, ctt_pkg::M_NUMBER: begin
                    if (r_hv) begin
                        res[nres[0]] = ctt_pkg::mk_tok(
                            (r_mode == ctt_pkg::M_IDENT) ? ctt_pkg::K_IDENT : ctt_pkg::K_NUMBER,
                            r_held, 1'b1, r_hf, 1'b1, line16);
                        nres = nres + 2'd1;
                    end
                end
                ctt_pkg::M_QUOTED: begin
                    res[nres[0]] = ctt_pkg::mk_tok(ctt_pkg::K_OPENSTR, 8'd0, 1'b0, 1'b1, 1'b1,
                                                   line16);
                    nres = nres + 2'd1;
                end
                ctt_pkg::M_MINUS: begin
                    res[nres[0]] = ctt_pkg::mk_tok(ctt_pkg::K_BAD, 8'd0, 1'b0, 1'b1, 1'b1,
                                                   line16);
                    nres = nres + 2'd1;
                end
                default: ;
            endcase
            res[nres[0]] = ctt_pkg::mk_tok(ctt_pkg::K_EOF, 8'd0, 1'b0, 1'b1, 1'b1, line16);
            nres   = nres + 2'd1;
            n_mode = ctt_pkg::M_IDLE;
            n_held = 8'd0;
            n_hv   = 1'b0;
            n_hf   = 1'b0;
            n_line = ctt_pkg::LINE_BITS'(1);
            n_nl   = 1'b0;
        end else begin
            unique case (r_mode) inside
                ctt_pkg::M_ERROR: ;
                ctt_pkg::M_COMMENT: begin
                    if ((c == ctt_pkg::C_LF) || (c == ctt_pkg::C_CR)) begin
                        n_mode  = ctt_pkg::M_IDLE;
                        do_disp = 1'b1;
                    end
                end
                ctt_pkg::M_QUOTED: begin
                    if (c == ctt_pkg::C_QUOTE) begin
                        res[0] = r_hv
                            ? ctt_pkg::mk_tok(ctt_pkg::K_STRING, r_held, 1'b1, r_hf, 1'b1, line16)
                            : ctt_pkg::mk_tok(ctt_pkg::K_STRING, 8'd0, 1'b0, 1'b1, 1'b1, line16);
                        nres   = 2'd1;
                        n_hv   = 1'b0;
                        n_mode = ctt_pkg::M_IDLE;
                    end else begin
                        if (r_hv) begin
                            res[0] = ctt_pkg::mk_tok(ctt_pkg::K_STRING, r_held, 1'b1, r_hf,
                                                     1'b0, line16);
                            nres   = 2'd1;
                        end
                        n_held = c;
                        n_hv   = 1'b1;
                        n_hf   = !r_hv;
                    end
                end
                ctt_pkg::M_IDENT, ctt_pkg::M_NUMBER: begin
                    if ((r_mode == ctt_pkg::M_IDENT) ? ctt_pkg::is_identch(c)
                                                     : ctt_pkg::is_numch(c)) begin
                        res[0] = ctt_pkg::mk_tok(
                            (r_mode == ctt_pkg::M_IDENT) ? ctt_pkg::K_IDENT : ctt_pkg::K_NUMBER,
                            r_held, 1'b1, r_hf, 1'b0, line16);
                        nres   = 2'd1;
                        n_held = c;
                        n_hv   = 1'b1;
                        n_hf   = 1'b0;
                    end else begin
                        if (r_hv) begin
                            res[0] = ctt_pkg::mk_tok(
                                (r_mode == ctt_pkg::M_IDENT) ? ctt_pkg::K_IDENT
                                                             : ctt_pkg::K_NUMBER,
                                r_held, 1'b1, r_hf, 1'b1, line16);
                            nres   = 2'd1;
                        end
                        n_hv    = 1'b0;
                        n_mode  = ctt_pkg::M_IDLE;
                        do_disp = 1'b1;
                    end
                end
                ctt_pkg::M_MINUS: begin
                    if (ctt_pkg::is_numch(c)) begin
                        res[0] = ctt_pkg::mk_tok(ctt_pkg::K_NUMBER, ctt_pkg::C_MINUS, 1'b1,
                                                 1'b1, 1'b0, line16);
                        nres   = 2'd1;
                        n_held = c;
                        n_hv   = 1'b1;
                        n_hf   = 1'b0;
                        n_mode = ctt_pkg::M_NUMBER;
                    end else begin
                        res[0] = ctt_pkg::mk_tok(ctt_pkg::K_BAD, c, 1'b1, 1'b1, 1'b1, line16);
                        nres   = 2'd1;
                        n_mode = ctt_pkg::M_ERROR;
                    end
                end
                default: begin
                    n_mode  = ctt_pkg::M_IDLE;
                    do_disp = 1'b1;
                end
            endcase

            // Start-of-token handling for the current byte.
            if (do_disp) begin
                if (r_nl && (c == ctt_pkg::C_CR)) begin
                    n_nl = 1'b0;
                end else if ((c == ctt_pkg::C_LF) || (c == ctt_pkg::C_CR)) begin
                    if (r_line != '1) begin
                        n_line = r_line + ctt_pkg::LINE_BITS'(1);
                    end
                    n_nl = 1'b1;
                end else begin
                    n_nl = 1'b0;
                    unique case (c) inside
                        ctt_pkg::C_SPACE, ctt_pkg::C_TAB: ;
                        ctt_pkg::C_HASH:  n_mode = ctt_pkg::M_COMMENT;
                        ctt_pkg::C_COLON, ctt_pkg::C_COMMA, ctt_pkg::C_EQUALS,
                        ctt_pkg::C_SEMI, ctt_pkg::C_LBRACE, ctt_pkg::C_RBRACE: begin
                            res[nres[0]] = ctt_pkg::mk_tok(
                                (c == ctt_pkg::C_COLON)  ? ctt_pkg::K_COLON :
                                (c == ctt_pkg::C_COMMA)  ? ctt_pkg::K_COMMA :
                                (c == ctt_pkg::C_EQUALS) ? ctt_pkg::K_EQUALS :
                                (c == ctt_pkg::C_SEMI)   ? ctt_pkg::K_SEMICOLON :
                                (c == ctt_pkg::C_LBRACE) ? ctt_pkg::K_OPEN : ctt_pkg::K_CLOSE,
                                c, 1'b1, 1'b1, 1'b1, line16);
                            nres = nres + 2'd1;
                        end
                        ctt_pkg::C_QUOTE: begin
                            n_mode = ctt_pkg::M_QUOTED;
                            n_hv   = 1'b0;
                        end
                        ctt_pkg::C_MINUS: n_mode = ctt_pkg::M_MINUS;
                        default: begin
                            if (ctt_pkg::is_letter(c)) begin
                                n_mode = ctt_pkg::M_IDENT;
                                n_held = c;
                                n_hv   = 1'b1;
                                n_hf   = 1'b1;
                            end else if (ctt_pkg::is_numch(c)) begin
                                n_mode = ctt_pkg::M_NUMBER;
                                n_held = c;
                                n_hv   = 1'b1;
                                n_hf   = 1'b1;
                            end else begin
                                res[nres[0]] = ctt_pkg::mk_tok(ctt_pkg::K_BAD, c, 1'b1, 1'b1,
                                                               1'b1, line16);
                                nres   = nres + 2'd1;
                                n_mode = ctt_pkg::M_ERROR;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Scanner state advances only on an input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ctt_pkg::M_IDLE;
            r_held <= 8'd0;
            r_hv   <= 1'b0;
            r_hf   <= 1'b0;
            r_line <= ctt_pkg::LINE_BITS'(1);
            r_nl   <= 1'b0;
        end else if (in_xfer) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_hv   <= n_hv;
            r_hf   <= n_hf;
            r_line <= n_line;
            r_nl   <= n_nl;
        end
    end

    // Result queue payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            if (nres != 2'd0) begin
                r_fifo[r_wp] <= res[0];
            end
            if (nres == 2'd2) begin
                r_fifo[r_wp + ctt_pkg::FIFO_AW'(1)] <= res[1];
            end
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (in_xfer) begin
                r_wp <= r_wp + ctt_pkg::FIFO_AW'(in_xfer ? nres : 2'd0);
            end
            if (out_xfer) begin
                r_rp <= r_rp + ctt_pkg::FIFO_AW'(1);
            end
            r_cnt <= r_cnt + (ctt_pkg::FIFO_AW+1)'(in_xfer ? nres : 2'd0)
                           - (ctt_pkg::FIFO_AW+1)'(out_xfer);
        end
    end

    assign o_out.valid          = (r_cnt != '0);
    assign o_out.token_kind     = r_fifo[r_rp].token_kind;
    assign o_out.token_char     = r_fifo[r_rp].token_char;
    assign o_out.char_valid     = r_fifo[r_rp].char_valid;
    assign o_out.first_of_token = r_fifo[r_rp].first_of_token;
    assign o_out.last_of_token  = r_fifo[r_rp].last_of_token;
    assign o_out.line_number    = r_fifo[r_rp].line_number;

endmodule

// ===== rtl/core/ctt_checker.sv =====
// Port-level checks for the tokenizer, bound to the top level.
module ctt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_token_kind,
    input logic [7:0]  i_token_char,
    input logic        i_char_valid,
    input logic        i_first_of_token,
    input logic        i_last_of_token
);

    // Hold a stalled result until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_token_kind)
            && $stable(i_token_char) && $stable(i_first_of_token))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_token_kind <= ctt_pkg::K_OPENSTR))
        else $error("token kind out of range");

    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_token_kind == ctt_pkg::K_EOF)
            |-> i_first_of_token && i_last_of_token && !i_char_valid)
        else $error("malformed EOF result");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_char_valid |-> (i_token_char == 8'd0))
        else $error("char byte set without char_valid");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_token_kind     (o_out.token_kind),
    .i_token_char     (o_out.token_char),
    .i_char_valid     (o_out.char_valid),
    .i_first_of_token (o_out.first_of_token),
    .i_last_of_token  (o_out.last_of_token)
);

// ===== dv/config_text_tokenizer_tb.sv =====
// Self-checking testbench for the configuration text tokenizer.
module config_text_tokenizer_tb;
    import ctt_pkg::*;

    localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string DIGITS  = "0123456789";

    logic i_clk;
    logic i_rst_n;

    ctt_in_if  in_if ();
    ctt_out_if out_if ();

    config_text_tokenizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Scanner state mirrored on the testbench side
    logic [3:0]           scan_state;
    logic [7:0]           tok_byte;
    logic                 tok_byte_vld;
    logic                 tok_byte_first;
    logic [LINE_BITS-1:0] line_cnt;
    logic                 line_ended;
    t_tok                 expected_tokens[$];

    int errors         = 0;
    int items_sent     = 0;
    int docs_sent      = 0;
    int tokens_checked = 0;
    int tx_max_gap     = 17;
    int rx_max_gap     = 17;
    int rx_hold        = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 1000000);
        $display("tb: failure");
        $finish;
    end

    function automatic logic alpha_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic num_char(logic [7:0] c);
        return digit_char(c) || c == C_DOT;
    endfunction

    function automatic logic word_char(logic [7:0] c);
        return alpha_char(c) || digit_char(c) || c == C_UNDER;
    endfunction

    function automatic void clear_scanner();
        scan_state     = M_IDLE;
        tok_byte       = 8'd0;
        tok_byte_vld   = 1'b0;
        tok_byte_first = 1'b0;
        line_cnt       = LINE_BITS'(1);
        line_ended     = 1'b0;
    endfunction

    function automatic void expect_token(logic [3:0] kind, logic [7:0] c, logic cv,
                                         logic first, logic last);
        t_tok t;
        t.token_kind     = kind;
        t.token_char     = cv ? c : 8'd0;
        t.char_valid     = cv;
        t.first_of_token = first;
        t.last_of_token  = last;
        t.line_number    = line_cnt[15:0];
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void flush_word(logic [3:0] kind);
        if (tok_byte_vld) begin
            expect_token(kind, tok_byte, 1'b1, tok_byte_first, 1'b1);
        end
        tok_byte_vld = 1'b0;
    endfunction

    function automatic void hold_char(logic [7:0] c, logic first);
        tok_byte       = c;
        tok_byte_vld   = 1'b1;
        tok_byte_first = first;
    endfunction

    // Byte seen with no token open
    function automatic void start_token(logic [7:0] c);
        if (line_ended && c == C_CR) begin
            line_ended = 1'b0;
            return;
        end
        if (c == C_LF || c == C_CR) begin
            if (line_cnt != '1) begin
                line_cnt = line_cnt + LINE_BITS'(1);
            end
            line_ended = 1'b1;
            return;
        end
        line_ended = 1'b0;
        case (c)
            C_SPACE, C_TAB: ;
            C_HASH:   scan_state = M_COMMENT;
            C_COLON:  expect_token(K_COLON, c, 1'b1, 1'b1, 1'b1);
            C_COMMA:  expect_token(K_COMMA, c, 1'b1, 1'b1, 1'b1);
            C_EQUALS: expect_token(K_EQUALS, c, 1'b1, 1'b1, 1'b1);
            C_SEMI:   expect_token(K_SEMICOLON, c, 1'b1, 1'b1, 1'b1);
            C_LBRACE: expect_token(K_OPEN, c, 1'b1, 1'b1, 1'b1);
            C_RBRACE: expect_token(K_CLOSE, c, 1'b1, 1'b1, 1'b1);
            C_QUOTE: begin
                scan_state   = M_QUOTED;
                tok_byte_vld = 1'b0;
            end
            C_MINUS:  scan_state = M_MINUS;
            default: begin
                if (alpha_char(c)) begin
                    scan_state = M_IDENT;
                    hold_char(c, 1'b1);
                end else if (num_char(c)) begin
                    scan_state = M_NUMBER;
                    hold_char(c, 1'b1);
                end else begin
                    expect_token(K_BAD, c, 1'b1, 1'b1, 1'b1);
                    scan_state = M_ERROR;
                end
            end
        endcase
    endfunction

    function automatic void tokenize_byte(logic [7:0] b, logic e);
        logic [3:0] kind;
        logic       more;
        logic       first;
        if (e || b == C_NUL) begin
            case (scan_state)
                M_IDENT:  flush_word(K_IDENT);
                M_NUMBER: flush_word(K_NUMBER);
                M_QUOTED: expect_token(K_OPENSTR, C_NUL, 1'b0, 1'b1, 1'b1);
                M_MINUS:  expect_token(K_BAD, C_NUL, 1'b0, 1'b1, 1'b1);
                default: ;
            endcase
            expect_token(K_EOF, C_NUL, 1'b0, 1'b1, 1'b1);
            clear_scanner();
            return;
        end
        case (scan_state)
            M_ERROR: ;
            M_COMMENT: begin
                if (b == C_LF || b == C_CR) begin
                    scan_state = M_IDLE;
                    start_token(b);
                end
            end
            M_QUOTED: begin
                if (b == C_QUOTE) begin
                    if (tok_byte_vld) begin
                        flush_word(K_STRING);
                    end else begin
                        expect_token(K_STRING, C_NUL, 1'b0, 1'b1, 1'b1);
                    end
                    scan_state = M_IDLE;
                end else begin
                    first = !tok_byte_vld;
                    if (tok_byte_vld) begin
                        expect_token(K_STRING, tok_byte, 1'b1, tok_byte_first, 1'b0);
                    end
                    hold_char(b, first);
                end
            end
            M_IDENT, M_NUMBER: begin
                kind = (scan_state == M_IDENT) ? K_IDENT : K_NUMBER;
                more = (scan_state == M_IDENT) ? word_char(b) : num_char(b);
                if (more) begin
                    expect_token(kind, tok_byte, 1'b1, tok_byte_first, 1'b0);
                    hold_char(b, 1'b0);
                end else begin
                    flush_word(kind);
                    scan_state = M_IDLE;
                    start_token(b);
                end
            end
            M_MINUS: begin
                if (num_char(b)) begin
                    expect_token(K_NUMBER, C_MINUS, 1'b1, 1'b1, 1'b0);
                    hold_char(b, 1'b0);
                    scan_state = M_NUMBER;
                end else begin
                    expect_token(K_BAD, b, 1'b1, 1'b1, 1'b1);
                    scan_state = M_ERROR;
                end
            end
            default: begin
                scan_state = M_IDLE;
                start_token(b);
            end
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_token();
        t_tok want;
        if (expected_tokens.size() == 0) begin
            $error("token_kind: expected no result, got %0d (char %0h)",
                   out_if.token_kind, out_if.token_char);
            errors++;
        end else begin
            want = expected_tokens.pop_front();
            check_field("token_kind", want.token_kind, out_if.token_kind);
            check_field("token_char", want.token_char, out_if.token_char);
            check_field("char_valid", want.char_valid, out_if.char_valid);
            check_field("first_of_token", want.first_of_token, out_if.first_of_token);
            check_field("last_of_token", want.last_of_token, out_if.last_of_token);
            check_field("line_number", want.line_number, out_if.line_number);
            tokens_checked++;
        end
    endfunction

    // Check each result transfer, then predict from each byte transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                check_token();
            end
            if (in_if.valid && in_if.ready) begin
                tokenize_byte(in_if.data_byte, in_if.is_end);
            end
        end
    end

    initial begin : result_sink
        int gap;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                out_if.ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end
            gap = $urandom_range(0, rx_max_gap);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic e);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.is_end    <= e;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    // End of document: either the end flag with a random byte, or a zero byte
    task automatic send_end();
        if ($urandom_range(0, 1)) begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_item(C_NUL, 1'b0);
        end
        docs_sent++;
    endtask

    function automatic logic [7:0] pick_from(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    task automatic test_punctuation_and_words();
        send_text("{a_9:-.5,7=\"\";}\t 7");
        send_end();
    endtask

    task automatic test_strings_and_lines();
        // newline inside a string, comment ended by LF, swallowed CR, open string at end
        send_text("\"a\012b\"#c\012\015\015\012\"q");
        send_end();
    endtask

    task automatic test_errors();
        send_text("-a\012");
        send_item(8'hA5, 1'b1);
        send_item(C_MINUS, 1'b0);
        send_item(C_NUL, 1'b0);
        send_text("\377x");
        send_end();
    endtask

    task automatic test_backpressure();
        tx_max_gap = 0;
        rx_max_gap = 0;
        rx_hold    = 150;
        repeat (12) send_text(":ab_c ");
        send_end();
        tx_max_gap = 17;
        rx_max_gap = 17;
    endtask

    task automatic send_random_doc();
        int         n_tok;
        int         pick;
        int         len;
        logic [7:0] c;
        n_tok = $urandom_range(1, 14);
        for (int k = 0; k < n_tok; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                send_item(pick_from(":,=;{}"), 1'b0);
            end else if (pick < 38) begin
                send_item(pick_from(LETTERS), 1'b0);
                len = $urandom_range(0, 5);
                repeat (len) send_item(pick_from({LETTERS, DIGITS, "_"}), 1'b0);
            end else if (pick < 54) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_item(C_MINUS, 1'b0);
                end
                len = $urandom_range(1, 5);
                repeat (len) send_item(pick_from({DIGITS, "."}), 1'b0);
            end else if (pick < 66 || pick >= 97) begin
                send_item(C_QUOTE, 1'b0);
                len = $urandom_range(0, 5);
                repeat (len) begin
                    c = 8'($urandom_range(1, 255));
                    if (c == C_QUOTE) begin
                        c = C_UNDER;
                    end
                    send_item(c, 1'b0);
                end
                // leave the string open and let the end item close the document
                if (pick >= 97) begin
                    break;
                end
                send_item(C_QUOTE, 1'b0);
            end else if (pick < 73) begin
                send_item(C_HASH, 1'b0);
                len = $urandom_range(0, 4);
                repeat (len) begin
                    c = 8'($urandom_range(1, 255));
                    if (c == C_LF || c == C_CR) begin
                        c = C_SPACE;
                    end
                    send_item(c, 1'b0);
                end
                send_item(pick_from("\012\015"), 1'b0);
            end else if (pick < 82) begin
                len = $urandom_range(1, 3);
                repeat (len) send_item(pick_from("\012\015"), 1'b0);
            end else if (pick < 90) begin
                send_item(pick_from(" \t"), 1'b0);
            end else if (pick < 94) begin
                send_item(8'($urandom_range(1, 255)), 1'b0);
            end else begin
                send_item(C_MINUS, 1'b0);
                send_item(8'($urandom_range(1, 255)), 1'b0);
            end
            if ($urandom_range(0, 1)) begin
                send_item(pick_from(" \t\012"), 1'b0);
            end
        end
        send_end();
    endtask

    task automatic test_random();
        int start;
        start = items_sent;
        while (items_sent - start < 420) begin
            tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 17;
            rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 17;
            send_random_doc();
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.data_byte <= C_NUL;
        in_if.is_end    <= 1'b0;
        clear_scanner();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_punctuation_and_words();
        test_strings_and_lines();
        test_errors();
        test_backpressure();
        test_random();

        in_if.valid <= 1'b0;
        rx_max_gap = 0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("summary: %0d bytes in %0d documents, %0d token results checked",
                 items_sent, docs_sent, tokens_checked);
        $display("summary: punctuation, words, strings, comments, line ends, "
                 , "error paths, output stall and random documents");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
